/* hdl/nlmcs_pkg.sv */
// ----------------------------------------------------------------------------
// nlmcs_pkg
// types and codes shared by the nested loop motion command sequencer
// ----------------------------------------------------------------------------
package nlmcs_pkg;

    // request modes
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_ADVANCE = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OP       = 3'd0;
    localparam logic [2:0] ST_FINISHED = 3'd1;
    localparam logic [2:0] ST_WALK     = 3'd2;
    localparam logic [2:0] ST_OVER     = 3'd3;
    localparam logic [2:0] ST_UNDER    = 3'd4;
    localparam logic [2:0] ST_ACCEPTED = 3'd5;

    // command word low-half markers and the endless loop count
    localparam logic [15:0] LOW_LOOP_OPEN  = 16'h8000;
    localparam logic [15:0] LOW_LOOP_CLOSE = 16'h0000;
    localparam logic [15:0] COUNT_FOREVER  = 16'hFFFF;

    localparam int unsigned LEN_W = 11;

    typedef struct packed {
        logic [1:0]  mode;
        logic [9:0]  address;
        logic [31:0] command_word;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        direction;
        logic [14:0] interval;
    } out_item_t;

endpackage

/* hdl/nested_loop_motion_command_sequencer.sv */
// ----------------------------------------------------------------------------
// nested_loop_motion_command_sequencer
// walks a stored program of motion commands with nested counted loops
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_stall carry one request: load a command word, advance to the
//   next operation execution, or restart. every request gives exactly one
//   result on out_valid/out_stall (status, direction, interval).
//   cfg_valid/cfg_ready writes program_length; write it only while idle.
// request flow
//   load, restart and unused modes: the result is set on acceptance and then
//   loaded into the output register. advance: each store entry examined
//   (at most WALK_LIMIT, the operation found included) costs one read of
//   the synchronous program store and the loop stack, then one decision
//   step; the walk ends at the end of the program or at the walk limit in a
//   further read step. while halted the result is set on acceptance, and a
//   repeat of a running operation examines only that entry.
//   one request is in flight at a time; a new one is taken while the
//   previous result still waits in the output register.
// reset and stalls
//   reset clears pointer, nest level, repeat count, running and halted
//   flags, program_length and the output valid flag; the stores hold no reset
//   and need no clearing pass. a stalled result holds in the output register
//   and the block waits before loading the next one.
// ----------------------------------------------------------------------------
module nested_loop_motion_command_sequencer
    import nlmcs_pkg::*;
#(
    parameter int unsigned PROGRAM_DEPTH = 1024,
    parameter int unsigned NEST_DEPTH    = 256,
    parameter int unsigned WALK_LIMIT    = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_data,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_data,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LEN_W-1:0]    cfg_data
);

    // widths derived from the parameters
    localparam int unsigned AW = $clog2(PROGRAM_DEPTH);
    localparam int unsigned NW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int unsigned LW = $clog2(NEST_DEPTH + 1);
    localparam int unsigned SW = $clog2(WALK_LIMIT + 1);

    typedef struct packed {
        logic [15:0]      remaining;
        logic [LEN_W-1:0] start;
    } nest_entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_EXEC,
        S_EMIT
    } state_t;

    // memories
    logic [31:0]  prog_mem [PROGRAM_DEPTH];
    nest_entry_t  nest_mem [NEST_DEPTH];
    logic [31:0]  prog_q;
    nest_entry_t  nest_q;

    // control state
    state_t           state_reg, state_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [LEN_W-1:0] ptr_reg, ptr_next;
    logic [LW-1:0]    nest_reg, nest_next;
    logic [15:0]      repeats_reg, repeats_next;
    logic             active_reg, active_next;
    logic             halted_reg, halted_next;
    logic [SW-1:0]    steps_reg, steps_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    out_item_t        res_reg, res_next;
    out_item_t        out_data_reg;

    logic             in_accept;
    logic             emit_load;
    logic             prog_we;
    logic             prog_re;
    logic [AW-1:0]    prog_wa;
    logic [NW-1:0]    nest_ra;
    logic             nest_we;
    logic [NW-1:0]    nest_wa;
    nest_entry_t      nest_wd;
    logic [LEN_W-1:0] eff_len;
    logic [15:0]      word_low;
    logic [15:0]      word_count;
    logic [15:0]      run_count;
    logic             nest_full;
    logic             nest_empty;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // effective program length is capped by the store depth
    assign eff_len = (32'(length_reg) < PROGRAM_DEPTH) ? length_reg
                                                       : LEN_W'(PROGRAM_DEPTH);

    assign word_low   = prog_q[15:0];
    assign word_count = prog_q[31:16];
    // repeat count for this execution: running count or a freshly found one
    assign run_count  = active_reg ? repeats_reg : word_count;
    assign nest_full  = (nest_reg >= LW'(NEST_DEPTH));
    assign nest_empty = (nest_reg == '0);

    assign emit_load = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    // store write on a load request inside the store range
    assign prog_we = in_accept && (in_data.mode == MODE_LOAD)
                  && (32'(in_data.address) < PROGRAM_DEPTH);
    assign prog_wa = AW'(in_data.address);
    assign prog_re = (state_reg == S_STEP);
    assign nest_ra = NW'(nest_reg - LW'(1));

    // loop stack write: push on open, decrement of the top on a counted close
    always_comb
    begin
        nest_we = 1'b0;
        nest_wa = NW'(nest_reg);
        nest_wd = '{remaining: word_count, start: ptr_reg};
        if (state_reg == S_EXEC && !active_reg)
        begin
            if (word_low == LOW_LOOP_OPEN)
            begin
                nest_we = !nest_full;
            end
            else if (word_low == LOW_LOOP_CLOSE)
            begin
                nest_wa = nest_ra;
                nest_wd = '{remaining: nest_q.remaining - 16'd1, start: nest_q.start};
                nest_we = !nest_empty && (nest_q.remaining != COUNT_FOREVER)
                       && (nest_q.remaining != 16'd0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_mem[prog_wa] <= in_data.command_word;
        end
        if (prog_re)
        begin
            prog_q <= prog_mem[AW'(ptr_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nest_we)
        begin
            nest_mem[nest_wa] <= nest_wd;
        end
        if (prog_re)
        begin
            nest_q <= nest_mem[nest_ra];
        end
    end

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        length_next    = length_reg;
        ptr_next       = ptr_reg;
        nest_next      = nest_reg;
        repeats_next   = repeats_reg;
        active_next    = active_reg;
        halted_next    = halted_reg;
        steps_next     = steps_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;

        if (cfg_valid && cfg_ready)
        begin
            length_next = cfg_data;
        end

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_next   = '{status: ST_ACCEPTED, direction: 1'b0, interval: '0};
                    state_next = S_EMIT;
                    steps_next = '0;
                    if (in_data.mode == MODE_RESTART)
                    begin
                        ptr_next     = '0;
                        nest_next    = '0;
                        repeats_next = '0;
                        active_next  = 1'b0;
                        halted_next  = 1'b0;
                    end
                    else if (in_data.mode == MODE_ADVANCE)
                    begin
                        if (halted_reg)
                        begin
                            res_next.status = ST_FINISHED;
                        end
                        else
                        begin
                            state_next = S_STEP;
                        end
                    end
                end
            end

            S_STEP:
            begin
                // end of program and walk budget apply only between operations
                if (!active_reg && (ptr_reg >= eff_len))
                begin
                    res_next   = '{status: ST_FINISHED, direction: 1'b0, interval: '0};
                    state_next = S_EMIT;
                end
                else if (!active_reg && (steps_reg >= SW'(WALK_LIMIT)))
                begin
                    res_next   = '{status: ST_WALK, direction: 1'b0, interval: '0};
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                steps_next = steps_reg + SW'(1);
                if (active_reg || ((word_low != LOW_LOOP_OPEN)
                                && (word_low != LOW_LOOP_CLOSE)))
                begin
                    // one execution of the operation at the pointer
                    res_next   = '{status: ST_OP, direction: prog_q[15],
                                   interval: prog_q[14:0]};
                    state_next = S_EMIT;
                    if (run_count == 16'd0)
                    begin
                        active_next = 1'b0;
                        ptr_next    = ptr_reg + LEN_W'(1);
                    end
                    else
                    begin
                        active_next  = 1'b1;
                        repeats_next = run_count - 16'd1;
                    end
                end
                else if (word_low == LOW_LOOP_OPEN)
                begin
                    if (nest_full)
                    begin
                        halted_next = 1'b1;
                        res_next    = '{status: ST_OVER, direction: 1'b0, interval: '0};
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        nest_next  = nest_reg + LW'(1);
                        ptr_next   = ptr_reg + LEN_W'(1);
                        state_next = S_STEP;
                    end
                end
                else
                begin
                    if (nest_empty)
                    begin
                        halted_next = 1'b1;
                        res_next    = '{status: ST_UNDER, direction: 1'b0, interval: '0};
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_STEP;
                        if (nest_q.remaining == 16'd0)
                        begin
                            // loop done, pop it
                            nest_next = nest_reg - LW'(1);
                            ptr_next  = ptr_reg + LEN_W'(1);
                        end
                        else
                        begin
                            // jump back to the entry after the open
                            ptr_next = nest_q.start + LEN_W'(1);
                        end
                    end
                end
            end

            S_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            length_reg    <= '0;
            ptr_reg       <= '0;
            nest_reg      <= '0;
            repeats_reg   <= '0;
            active_reg    <= 1'b0;
            halted_reg    <= 1'b0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            ptr_reg       <= ptr_next;
            nest_reg      <= nest_next;
            repeats_reg   <= repeats_next;
            active_reg    <= active_next;
            halted_reg    <= halted_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (emit_load)
        begin
            out_data_reg <= res_reg;
        end
    end

endmodule
